// ===== rtl/dual_motor_lift_controller_top_macros.svh =====
// ----------------------------------------------------------------------------
// Dual motor lift controller assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_MOTOR_LIFT_CONTROLLER_TOP_MACROS_SVH
`define DUAL_MOTOR_LIFT_CONTROLLER_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define DMLC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DMLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dmlc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmlc_pkg
// Types, codes and widths shared by the dual motor lift controller.
// ----------------------------------------------------------------------------
package dmlc_pkg;

	localparam int POS_WIDTH = 24;
	localparam int GOAL_WIDTH = POS_WIDTH + 1;
	// working width for sums of two positions plus doubled travel
	localparam int CALC_W = POS_WIDTH + 3;

	localparam int SPEED_W = 7;
	localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(100);
	localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(50);

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = (POS_WIDTH > SPEED_W) ? POS_WIDTH : SPEED_W;

	localparam logic [CFG_INDEX_W-1:0] REG_RUN_SPEED = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_SEEK_SPEED = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] REG_LOWER_A = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_UPPER_A = CFG_INDEX_W'(3);
	localparam logic [CFG_INDEX_W-1:0] REG_LOWER_B = CFG_INDEX_W'(4);
	localparam logic [CFG_INDEX_W-1:0] REG_UPPER_B = CFG_INDEX_W'(5);
	localparam logic [CFG_INDEX_W-1:0] REG_SYNC_TOL = CFG_INDEX_W'(6);

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_MOVE = 2'd1,
		ACT_STOP = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		MODE_STOP = 2'd0,
		MODE_VEL = 2'd1,
		MODE_SEEK = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		BRAKE_COAST = 2'd0,
		BRAKE_BRAKE = 2'd1,
		BRAKE_HOLD = 2'd2
	} brake_t;

	// Input beat payload, first member in the highest bits.
	typedef struct packed {
		logic [1:0] stop_kind;
		logic signed [GOAL_WIDTH-1:0] goal_sum;
		logic done_b;
		logic done_a;
		logic signed [POS_WIDTH-1:0] position_b;
		logic signed [POS_WIDTH-1:0] position_a;
		logic drive_enabled;
		logic down_btn;
		logic up_btn;
	} in_data_t;

	typedef struct packed {
		logic [1:0] action;
		in_data_t data;
	} in_item_t;

	typedef struct packed {
		logic in_sync;
		logic all_done;
		logic signed [POS_WIDTH-1:0] goal_b;
		logic signed [POS_WIDTH-1:0] goal_a;
		logic [1:0] brake_used;
		logic signed [7:0] drive_speed;
		logic [1:0] mode_b;
		logic [1:0] mode_a;
	} out_item_t;

	localparam int IN_DATA_BITS = $bits(in_data_t);
	localparam int IN_TDATA_W = ((IN_DATA_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = $bits(out_item_t);
	localparam int OUT_TDATA_W = ((OUT_DATA_BITS + 7) / 8) * 8;

endpackage

// ===== rtl/dual_motor_lift_controller_top.sv =====
// ----------------------------------------------------------------------------
// Dual motor lift controller
// Run flag handling, open-loop drive and summed-position seek for two motors.
// ----------------------------------------------------------------------------
//  channel  | dir | carries
//  s_*      | in  | action (tuser), buttons, positions, done, goal sum, stop kind
//  m_*      | out | modes, speed, brake, goals, all_done, in_sync
//  cfg_*    | in  | register writes, index 0..6, no read-back
//
// One beat per cycle while the output is not stalled. A beat is registered in
// the input stage; its result is computed from that stage and the run flags
// and lands in the output register. A stalled output stalls the input stage
// only when it is also full. Reset clears the run flags, the stage valids and
// loads the register reset values.

module dual_motor_lift_controller_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// up_btn, down_btn, drive_enabled, position_a, position_b,
	// done_a, done_b, goal_sum, stop_kind
	input  logic [dmlc_pkg::IN_TDATA_W-1:0]     s_tdata,
	// action
	input  logic [1:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// mode_a, mode_b, drive_speed, brake_used, goal_a, goal_b,
	// all_done, in_sync
	output logic [dmlc_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                                cfg_we,
	input  logic [dmlc_pkg::CFG_INDEX_W-1:0]    cfg_addr,
	input  logic [dmlc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int PW = dmlc_pkg::POS_WIDTH;
	localparam int CW = dmlc_pkg::CALC_W;
	localparam int SW = dmlc_pkg::SPEED_W;

	// configuration
	logic [SW-1:0] run_speed_q;
	logic [SW-1:0] seek_speed_q;
	logic signed [PW-1:0] lower_a_q;
	logic signed [PW-1:0] upper_a_q;
	logic signed [PW-1:0] lower_b_q;
	logic signed [PW-1:0] upper_b_q;
	logic [PW-1:0] sync_tol_q;

	// state and pipeline
	logic run_up_q;
	logic run_down_q;
	logic v_s1;
	dmlc_pkg::in_item_t in_s1;
	logic m_tvalid_q;
	dmlc_pkg::out_item_t out_q;

	logic adv;
	logic load;
	logic stop_load;

	// datapath
	dmlc_pkg::out_item_t res;
	logic nxt_up;
	logic nxt_down;
	logic signed [CW-1:0] pa, pb, la, ua, lb, ub, goal, cur;
	logic signed [CW-1:0] r1, r2, rem, two_rem, up_lim, dn_lim, safe, delta, half;
	logic signed [CW-1:0] ta, tb, ta_min, tb_min, ga_c, gb_c, diff, mag;
	logic going_up;
	logic in_sync_c;
	logic [SW-1:0] run_sat;
	logic [SW-1:0] seek_sat;
	logic signed [7:0] run_signed;
	logic mov_up, mov_dn;

	assign adv = !m_tvalid_q || m_tready;
	assign load = v_s1 && adv;
	assign stop_load = load && (in_s1.action == dmlc_pkg::ACT_STOP);
	assign s_tready = !v_s1 || adv;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = dmlc_pkg::OUT_TDATA_W'(out_q);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_speed_q <= dmlc_pkg::SPEED_RESET;
			seek_speed_q <= dmlc_pkg::SPEED_RESET;
			lower_a_q <= '0;
			upper_a_q <= '0;
			lower_b_q <= '0;
			upper_b_q <= '0;
			sync_tol_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				dmlc_pkg::REG_RUN_SPEED: run_speed_q <= cfg_data[SW-1:0];
				dmlc_pkg::REG_SEEK_SPEED: seek_speed_q <= cfg_data[SW-1:0];
				dmlc_pkg::REG_LOWER_A: lower_a_q <= cfg_data[PW-1:0];
				dmlc_pkg::REG_UPPER_A: upper_a_q <= cfg_data[PW-1:0];
				dmlc_pkg::REG_LOWER_B: lower_b_q <= cfg_data[PW-1:0];
				dmlc_pkg::REG_UPPER_B: upper_b_q <= cfg_data[PW-1:0];
				dmlc_pkg::REG_SYNC_TOL: sync_tol_q <= cfg_data[PW-1:0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_s1.action <= s_tuser;
			in_s1.data <= dmlc_pkg::in_data_t'(s_tdata[dmlc_pkg::IN_DATA_BITS-1:0]);
		end
	end

	// result computation
	always_comb begin
		pa = CW'(in_s1.data.position_a);
		pb = CW'(in_s1.data.position_b);
		la = CW'(lower_a_q);
		ua = CW'(upper_a_q);
		lb = CW'(lower_b_q);
		ub = CW'(upper_b_q);
		goal = CW'(in_s1.data.goal_sum);

		run_sat = (run_speed_q > dmlc_pkg::SPEED_MAX) ? dmlc_pkg::SPEED_MAX : run_speed_q;
		seek_sat = (seek_speed_q > dmlc_pkg::SPEED_MAX) ? dmlc_pkg::SPEED_MAX : seek_speed_q;

		diff = pa - pb;
		mag = (diff < 0) ? -diff : diff;
		in_sync_c = $unsigned(mag) <= CW'(sync_tol_q);

		// seek: limit summed target by the smaller remaining travel
		cur = pa + pb;
		going_up = goal > cur;
		r1 = going_up ? (ua - pa) : (pa - la);
		r2 = going_up ? (ub - pb) : (pb - lb);
		rem = (r1 < r2) ? r1 : r2;
		if (rem < 0) begin
			rem = '0;
		end
		two_rem = rem <<< 1;
		up_lim = cur + two_rem;
		dn_lim = cur - two_rem;
		if (going_up) begin
			safe = (goal < up_lim) ? goal : up_lim;
		end else begin
			safe = (goal > dn_lim) ? goal : dn_lim;
		end
		delta = safe - cur;
		half = delta >>> 1;
		ta = pa + half;
		tb = pb + half;
		// crossed limits resolve to the lower limit
		ta_min = (ta < ua) ? ta : ua;
		tb_min = (tb < ub) ? tb : ub;
		ga_c = (ta_min > la) ? ta_min : la;
		gb_c = (tb_min > lb) ? tb_min : lb;

		// tick: up toggles first, so down wins on a double press
		nxt_up = run_up_q;
		nxt_down = run_down_q;
		if (in_s1.data.up_btn) begin
			nxt_up = !nxt_up;
			nxt_down = 1'b0;
		end
		if (in_s1.data.down_btn) begin
			nxt_down = !nxt_down;
			nxt_up = 1'b0;
		end
		run_signed = nxt_up ? $signed({1'b0, run_sat}) : -$signed({1'b0, run_sat});
		mov_up = nxt_up && (run_sat != '0);
		mov_dn = nxt_down && (run_sat != '0);

		res.mode_a = dmlc_pkg::MODE_STOP;
		res.mode_b = dmlc_pkg::MODE_STOP;
		res.drive_speed = '0;
		res.brake_used = dmlc_pkg::BRAKE_HOLD;
		res.goal_a = '0;
		res.goal_b = '0;
		res.all_done = in_s1.data.done_a && in_s1.data.done_b;
		res.in_sync = in_sync_c;

		case (in_s1.action)
			dmlc_pkg::ACT_TICK: begin
				if (in_s1.data.drive_enabled && (nxt_up != nxt_down)) begin
					res.drive_speed = run_signed;
					if (!((mov_up && pa >= ua) || (mov_dn && pa <= la))) begin
						res.mode_a = dmlc_pkg::MODE_VEL;
					end
					if (!((mov_up && pb >= ub) || (mov_dn && pb <= lb))) begin
						res.mode_b = dmlc_pkg::MODE_VEL;
					end
				end
			end
			dmlc_pkg::ACT_MOVE: begin
				res.mode_a = dmlc_pkg::MODE_SEEK;
				res.mode_b = dmlc_pkg::MODE_SEEK;
				res.drive_speed = 8'({1'b0, seek_sat});
				res.brake_used = dmlc_pkg::BRAKE_COAST;
				res.goal_a = ga_c[PW-1:0];
				res.goal_b = gb_c[PW-1:0];
			end
			dmlc_pkg::ACT_STOP: begin
				res.brake_used = (in_s1.data.stop_kind > dmlc_pkg::BRAKE_HOLD) ?
					dmlc_pkg::BRAKE_HOLD : in_s1.data.stop_kind;
				res.all_done = 1'b0;
				res.in_sync = 1'b0;
			end
			default: ;
		endcase
	end

	// run flags and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_up_q <= 1'b0;
			run_down_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (adv) begin
				m_tvalid_q <= v_s1;
			end
			if (load) begin
				case (in_s1.action)
					dmlc_pkg::ACT_TICK: begin
						run_up_q <= nxt_up;
						run_down_q <= nxt_down;
					end
					dmlc_pkg::ACT_STOP: begin
						run_up_q <= 1'b0;
						run_down_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

`include "dual_motor_lift_controller_top_macros.svh"

	`DMLC_ASSERT_NOW(a_flags_excl, 1'b1, !(run_up_q && run_down_q), "run flags both set")
	`DMLC_ASSERT_NEXT(a_accept_fills, s_tvalid && s_tready, v_s1, "accepted beat not staged")
	`DMLC_ASSERT_NEXT(a_load_shows, load, m_tvalid_q, "computed result not presented")
	`DMLC_ASSERT_NEXT(a_stop_clears, stop_load, !run_up_q && !run_down_q, "stop left a flag set")
	`DMLC_ASSERT_NOW(a_goal_a_range, v_s1 && (la <= ua), (ga_c >= la) && (ga_c <= ua), "goal A range")

endmodule

// ===== test/lift_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lift controller result checker
// Watches the register port and both streams, predicts the command beat that
// each accepted input beat causes, and compares it field by field in order.
// ----------------------------------------------------------------------------

module lift_result_checker
	import dmlc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic [1:0]             s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     fail_count,
	output int                     results_open,
	output int                     results_seen
);

	localparam int MAX_REPORTS = 40;

	logic [SPEED_W-1:0]          run_spd, seek_spd;
	logic signed [POS_WIDTH-1:0] lo_a, hi_a, lo_b, hi_b;
	logic [POS_WIDTH-1:0]        sync_tol;
	logic                        run_up, run_down;
	out_item_t                   cmds_due[$];
	out_item_t                   want, got;

	function automatic longint pct_cap(input logic [SPEED_W-1:0] v);
		return (v > SPEED_MAX) ? longint'(SPEED_MAX) : longint'(v);
	endfunction

	// Next motor command for one input beat; updates the run flags.
	function automatic out_item_t predict_lift_cmd(input logic [1:0] act, input in_data_t d);
		longint    pa, pb, la, ua, lb, ub, gs, cur, r1, r2, rem, safe, delta, spd, ga, gb, sep;
		logic      going_up;
		out_item_t o;
		pa = longint'($signed(d.position_a));
		pb = longint'($signed(d.position_b));
		la = longint'(lo_a);
		ua = longint'(hi_a);
		lb = longint'(lo_b);
		ub = longint'(hi_b);
		gs = longint'($signed(d.goal_sum));
		sep = (pa > pb) ? pa - pb : pb - pa;
		o = '0;
		o.brake_used = BRAKE_HOLD;
		o.all_done = d.done_a & d.done_b;
		o.in_sync = (sep <= longint'(sync_tol));
		case (act)
			ACT_TICK: begin
				if (d.up_btn) begin
					run_up = !run_up;
					run_down = 1'b0;
				end
				if (d.down_btn) begin
					run_down = !run_down;
					run_up = 1'b0;
				end
				if (d.drive_enabled && (run_up != run_down)) begin
					spd = run_up ? pct_cap(run_spd) : -pct_cap(run_spd);
					// a motor sitting at its limit in the running direction is held
					o.mode_a = ((spd > 0 && pa >= ua) || (spd < 0 && pa <= la)) ? MODE_STOP : MODE_VEL;
					o.mode_b = ((spd > 0 && pb >= ub) || (spd < 0 && pb <= lb)) ? MODE_STOP : MODE_VEL;
					o.drive_speed = 8'(spd);
				end
			end
			ACT_MOVE: begin
				cur = pa + pb;
				going_up = gs > cur;
				r1 = going_up ? ua - pa : pa - la;
				r2 = going_up ? ub - pb : pb - lb;
				rem = (r1 < r2) ? r1 : r2;
				if (rem < 0)
					rem = 0;
				if (going_up)
					safe = (gs < cur + 2 * rem) ? gs : cur + 2 * rem;
				else
					safe = (gs > cur - 2 * rem) ? gs : cur - 2 * rem;
				delta = (safe - cur) >>> 1;
				ga = (pa + delta < ua) ? pa + delta : ua;
				gb = (pb + delta < ub) ? pb + delta : ub;
				// lower limit wins when the limits are crossed
				if (ga < la)
					ga = la;
				if (gb < lb)
					gb = lb;
				o.mode_a = MODE_SEEK;
				o.mode_b = MODE_SEEK;
				o.drive_speed = 8'(pct_cap(seek_spd));
				o.brake_used = BRAKE_COAST;
				o.goal_a = POS_WIDTH'(ga);
				o.goal_b = POS_WIDTH'(gb);
			end
			ACT_STOP: begin
				run_up = 1'b0;
				run_down = 1'b0;
				o.brake_used = (d.stop_kind > BRAKE_HOLD) ? BRAKE_HOLD : d.stop_kind;
				o.all_done = 1'b0;
				o.in_sync = 1'b0;
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic check_field(input string name, input longint exp_v, input longint act_v);
		if (exp_v != act_v) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_spd <= SPEED_RESET;
			seek_spd <= SPEED_RESET;
			lo_a <= '0;
			hi_a <= '0;
			lo_b <= '0;
			hi_b <= '0;
			sync_tol <= '0;
			run_up = 1'b0;
			run_down = 1'b0;
			cmds_due.delete();
			fail_count = 0;
			results_open = 0;
			results_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_RUN_SPEED:  run_spd <= cfg_data[SPEED_W-1:0];
					REG_SEEK_SPEED: seek_spd <= cfg_data[SPEED_W-1:0];
					REG_LOWER_A:    lo_a <= cfg_data[POS_WIDTH-1:0];
					REG_UPPER_A:    hi_a <= cfg_data[POS_WIDTH-1:0];
					REG_LOWER_B:    lo_b <= cfg_data[POS_WIDTH-1:0];
					REG_UPPER_B:    hi_b <= cfg_data[POS_WIDTH-1:0];
					REG_SYNC_TOL:   sync_tol <= cfg_data[POS_WIDTH-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[OUT_DATA_BITS-1:0];
				results_seen++;
				if (cmds_due.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: unexpected beat, expected none, got %h", $time, m_tdata);
				end else begin
					want = cmds_due.pop_front();
					check_field("mode_a", want.mode_a, got.mode_a);
					check_field("mode_b", want.mode_b, got.mode_b);
					check_field("drive_speed", want.drive_speed, got.drive_speed);
					check_field("brake_used", want.brake_used, got.brake_used);
					check_field("goal_a", want.goal_a, got.goal_a);
					check_field("goal_b", want.goal_b, got.goal_b);
					check_field("all_done", want.all_done, got.all_done);
					check_field("in_sync", want.in_sync, got.in_sync);
				end
			end
			if (s_tvalid && s_tready)
				cmds_due.push_back(predict_lift_cmd(s_tuser, s_tdata[IN_DATA_BITS-1:0]));
			results_open = cmds_due.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dual motor lift controller testbench
// Directed beats for the limit, speed and brake corner cases under a few fixed
// register settings, then random phases with fresh settings, input gaps and
// output stalls. Checking is done by the result checker instance.
// ----------------------------------------------------------------------------

module tb_top;
	import dmlc_pkg::*;

	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_PHASES = 6;
	localparam int BEATS_PER_PHASE = 310;
	localparam longint POS_MAX = 64'sd8388607;
	localparam longint POS_MIN = -64'sd8388608;
	localparam longint SUM_MAX = 64'sd16777215;
	localparam longint SUM_MIN = -64'sd16777216;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [1:0]             s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	int                     fail_count, results_open, results_seen;

	// stimulus-side copy of limits and tolerance, for shaping positions and goal sums only
	int lo_a, hi_a, lo_b, hi_b, tol_now;
	int n_by_act[4];
	int n_settings = 0;
	bit tx_gaps = 1'b1, rx_stalls = 1'b1;
	int rdy_hold = 0;
	int rdy_pick;
	int quiet_cycles = 0;

	dual_motor_lift_controller_top u_dut (.*);

	lift_result_checker u_checker (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	// output side: bursts of ready, mostly short stalls, a few long ones
	always @(posedge clk) begin
		if (!rx_stalls) begin
			m_tready <= 1'b1;
		end else if (rdy_hold > 0) begin
			rdy_hold = rdy_hold - 1;
		end else begin
			rdy_pick = $urandom_range(0, 99);
			if (rdy_pick < 60) begin
				m_tready <= 1'b1;
				rdy_hold = $urandom_range(0, 6);
			end else if (rdy_pick < 92) begin
				m_tready <= 1'b0;
				rdy_hold = $urandom_range(0, 2);
			end else begin
				m_tready <= 1'b0;
				rdy_hold = $urandom_range(10, 40);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic longint clip(input longint v, input int bits);
		longint lim;
		lim = longint'(1) <<< (bits - 1);
		if (v < -lim)
			return -lim;
		if (v > lim - 1)
			return lim - 1;
		return v;
	endfunction

	function automatic int any_pos();
		logic signed [POS_WIDTH-1:0] v;
		v = POS_WIDTH'($urandom);
		return int'(v);
	endfunction

	function automatic in_data_t lift_inputs(input bit up, input bit dn, input bit en,
			input longint pa, input longint pb, input bit da, input bit db,
			input longint gs, input logic [1:0] kind);
		in_data_t d;
		d.up_btn = up;
		d.down_btn = dn;
		d.drive_enabled = en;
		d.position_a = POS_WIDTH'(pa);
		d.position_b = POS_WIDTH'(pb);
		d.done_a = da;
		d.done_b = db;
		d.goal_sum = GOAL_WIDTH'(gs);
		d.stop_kind = kind;
		return d;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// near the travel range most of the time, sometimes on a limit or anywhere
	function automatic longint pick_pos(input int lo, input int hi);
		int r, a, b;
		r = $urandom_range(0, 99);
		a = (lo < hi) ? lo : hi;
		b = (lo < hi) ? hi : lo;
		if (r < 10)
			return any_pos();
		if (r < 18)
			return lo;
		if (r < 25)
			return hi;
		return clip(longint'(a) - 64 + longint'($urandom_range(0, b - a + 128)), POS_WIDTH);
	endfunction

	task automatic send_item(input logic [1:0] act, input in_data_t d);
		int gap;
		gap = tx_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= IN_TDATA_W'(d);
		do @(posedge clk); while (!s_tready);
		n_by_act[act]++;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (results_open != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
		cfg_addr <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
	endtask

	task automatic load_settings(input int run, input int seek, input int la, input int ua,
			input int lb, input int ub, input int tol);
		settle();
		cfg_we <= 1'b1;
		put_reg(REG_RUN_SPEED, run);
		put_reg(REG_SEEK_SPEED, seek);
		put_reg(REG_LOWER_A, la);
		put_reg(REG_UPPER_A, ua);
		put_reg(REG_LOWER_B, lb);
		put_reg(REG_UPPER_B, ub);
		put_reg(REG_SYNC_TOL, tol);
		cfg_we <= 1'b0;
		@(posedge clk);
		lo_a = la;
		hi_a = ua;
		lo_b = lb;
		hi_b = ub;
		tol_now = tol;
		n_settings++;
	endtask

	task automatic random_settings();
		int r, la, ua, lb, ub, tol;
		r = $urandom_range(0, 99);
		la = int'($urandom_range(0, 20000)) - 10000;
		lb = int'($urandom_range(0, 20000)) - 10000;
		if (r < 65) begin
			ua = la + int'($urandom_range(0, 20000));
			ub = lb + int'($urandom_range(0, 20000));
		end else if (r < 80) begin
			ua = la - int'($urandom_range(1, 5000));
			ub = lb - int'($urandom_range(1, 5000));
		end else begin
			la = any_pos();
			ua = any_pos();
			lb = any_pos();
			ub = any_pos();
		end
		if ($urandom_range(0, 99) < 20)
			tol = int'($urandom_range(0, 24'hFFFFFF));
		else
			tol = int'($urandom_range(0, 300));
		load_settings($urandom_range(0, 127), $urandom_range(0, 127), la, ua, lb, ub, tol);
	endtask

	// ticks for half the beats, keeping the run flags alive, moves near the current sum
	task automatic random_item();
		logic [1:0]                   act;
		logic signed [GOAL_WIDTH-1:0] wild_goal;
		int                           r, near;
		longint                       pa, pb, gs, span;
		r = $urandom_range(0, 99);
		if (r < 50)
			act = ACT_TICK;
		else if (r < 80)
			act = ACT_MOVE;
		else if (r < 94)
			act = ACT_STOP;
		else
			act = ACT_SPARE;
		pa = pick_pos(lo_a, hi_a);
		if ($urandom_range(0, 99) < 35) begin
			near = (tol_now > 100000) ? 100000 : tol_now;
			pb = clip(pa - near - 1 + longint'($urandom_range(0, 2 * near + 2)), POS_WIDTH);
		end else begin
			pb = pick_pos(lo_b, hi_b);
		end
		r = $urandom_range(0, 99);
		if (r < 15) begin
			wild_goal = GOAL_WIDTH'($urandom);
			gs = wild_goal;
		end else if (r < 20) begin
			gs = pa + pb;
		end else begin
			span = ((hi_a > lo_a) ? hi_a - lo_a : lo_a - hi_a)
				+ ((hi_b > lo_b) ? hi_b - lo_b : lo_b - hi_b) + 64;
			if (span > SUM_MAX)
				span = SUM_MAX;
			gs = clip(pa + pb - span + longint'($urandom_range(0, 2 * span)), GOAL_WIDTH);
		end
		send_item(act, lift_inputs($urandom_range(0, 99) < 12, $urandom_range(0, 99) < 12,
			$urandom_range(0, 99) < 85, pa, pb, $urandom_range(0, 1), $urandom_range(0, 1),
			gs, $urandom_range(0, 3)));
	endtask

	initial begin
		lo_a = 0;
		hi_a = 0;
		lo_b = 0;
		hi_b = 0;
		tol_now = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: all limits at zero, so an upward tick holds both
		send_item(ACT_TICK, lift_inputs(1, 0, 1, 0, 0, 1, 1, 0, BRAKE_COAST));
		send_item(ACT_MOVE, lift_inputs(0, 0, 0, 5, -5, 0, 1, 100, BRAKE_COAST));
		send_item(ACT_STOP, lift_inputs(0, 0, 0, 0, 0, 1, 1, 0, BRAKE_BRAKE));

		load_settings(73, 100, -1000, 1000, -800, 1200, 50);
		send_item(ACT_TICK, lift_inputs(1, 0, 1, 0, 0, 1, 1, 0, BRAKE_COAST));
		// A at its upper limit while running up
		send_item(ACT_TICK, lift_inputs(0, 0, 1, 1000, 100, 1, 0, 0, BRAKE_COAST));
		send_item(ACT_TICK, lift_inputs(0, 1, 1, -1000, -800, 0, 0, 0, BRAKE_COAST));
		// both buttons at once: down wins
		send_item(ACT_TICK, lift_inputs(1, 1, 1, 0, 60, 1, 1, 0, BRAKE_COAST));
		send_item(ACT_TICK, lift_inputs(0, 0, 0, 0, 50, 0, 0, 0, BRAKE_COAST));
		send_item(ACT_TICK, lift_inputs(0, 1, 1, 0, 0, 1, 1, 0, BRAKE_COAST));
		send_item(ACT_MOVE, lift_inputs(0, 0, 0, 0, 0, 0, 0, 5000, BRAKE_COAST));
		send_item(ACT_MOVE, lift_inputs(0, 0, 0, 0, 0, 0, 0, -5000, BRAKE_COAST));
		send_item(ACT_MOVE, lift_inputs(0, 0, 0, 0, 0, 1, 1, 3, BRAKE_COAST));
		send_item(ACT_MOVE, lift_inputs(0, 0, 0, 0, 0, 1, 1, -3, BRAKE_COAST));
		// B already past its lower limit: no travel left
		send_item(ACT_MOVE, lift_inputs(0, 0, 0, 1500, -900, 0, 1, 0, BRAKE_COAST));
		send_item(ACT_STOP, lift_inputs(1, 0, 1, 0, 0, 1, 1, 0, BRAKE_COAST));
		send_item(ACT_STOP, lift_inputs(0, 1, 1, 0, 0, 1, 1, 0, BRAKE_BRAKE));
		send_item(ACT_STOP, lift_inputs(0, 0, 1, 0, 0, 1, 1, 0, BRAKE_HOLD));
		send_item(ACT_STOP, lift_inputs(0, 0, 0, 0, 0, 1, 1, 0, KIND_SPARE));
		send_item(ACT_SPARE, lift_inputs(1, 1, 1, POS_MAX, POS_MIN, 1, 1, SUM_MAX, KIND_SPARE));
		send_item(ACT_TICK, lift_inputs(1, 0, 1, POS_MAX, POS_MIN, 1, 1, SUM_MIN, KIND_SPARE));
		send_item(ACT_MOVE, lift_inputs(0, 0, 0, POS_MIN, POS_MAX, 1, 1, SUM_MIN, BRAKE_COAST));
		send_item(ACT_MOVE, lift_inputs(0, 0, 0, POS_MIN, POS_MIN, 1, 1, SUM_MAX, BRAKE_COAST));

		// zero run speed, seek speed above range, crossed limits, widest tolerance
		load_settings(0, 127, 500, -500, 8388607, -8388608, 16777215);
		send_item(ACT_TICK, lift_inputs(1, 0, 1, 0, 0, 0, 1, 0, BRAKE_COAST));
		send_item(ACT_MOVE, lift_inputs(0, 0, 1, 0, 0, 1, 1, 1000, BRAKE_COAST));

		// run speed above range, zero seek speed, full travel, zero tolerance
		load_settings(127, 0, -8388608, 8388607, -8388608, 8388607, 0);
		send_item(ACT_TICK, lift_inputs(0, 1, 1, 100, -100, 1, 1, 0, BRAKE_COAST));
		send_item(ACT_MOVE, lift_inputs(0, 0, 0, 0, 0, 1, 1, SUM_MAX, BRAKE_COAST));
		send_item(ACT_STOP, lift_inputs(0, 0, 0, 7, 7, 1, 1, 0, KIND_SPARE));

		for (int k = 0; k < RANDOM_PHASES; k++) begin
			random_settings();
			tx_gaps = (k % 2) == 1;
			rx_stalls = (k % 3) != 0;
			for (int i = 0; i < BEATS_PER_PHASE; i++)
				random_item();
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (results_open != 0);
		repeat (6) @(posedge clk);

		$display("Covered %0d ticks, %0d moves, %0d stops and %0d unused-action beats",
			n_by_act[ACT_TICK], n_by_act[ACT_MOVE], n_by_act[ACT_STOP], n_by_act[ACT_SPARE]);
		$display("under %0d register settings; %0d command beats compared",
			n_settings + 1, results_seen);
		if (fail_count == 0 && results_open == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
